// ===== rtl/core/c3f_pkg.sv =====
`default_nettype none
package c3f_pkg;

   // frame geometry
   localparam int MAX_WIDTH  = 1024;
   localparam int MAX_HEIGHT = 1024;
   localparam int COL_W      = $clog2(MAX_WIDTH);
   localparam int ROW_W      = $clog2(MAX_HEIGHT);
   localparam int DIM_W      = $clog2(MAX_WIDTH + 1);
   localparam int HDIM_W     = $clog2(MAX_HEIGHT + 1);
   localparam int MIN_DIM    = 3;

   // stream position counter saturates here
   localparam int POS_W   = 21;
   localparam int POS_CAP = (1 << POS_W) - 1;

   // pixel and coefficient formats
   localparam int PIX_W          = 8;
   localparam int PIX_MAX        = 255;
   localparam int COEF_W         = 16;
   localparam int COEF_FRAC_BITS = 8;
   localparam int TAPS           = 3;
   localparam int WIN_TAPS       = TAPS * TAPS;
   localparam int PROD_W         = PIX_W + 1 + COEF_W;
   localparam int SUM_W          = PROD_W + 4;

   // configuration registers
   localparam int CSR_IDX_W  = 3;
   localparam int CFG_DIM_W  = 11;
   localparam int COEF_ROW_W = TAPS * COEF_W;

   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_WIDTH     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_HEIGHT    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_COEF_NEXT_ROW   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_COEF_CENTER_ROW = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_COEF_PREV_ROW   = 3'd4;

   localparam logic [CFG_DIM_W-1:0]  RST_IMAGE_WIDTH  = 11'd1024;
   localparam logic [CFG_DIM_W-1:0]  RST_IMAGE_HEIGHT = 11'd1024;
   localparam logic [COEF_ROW_W-1:0] RST_COEF_NEXT    = 48'h0000_0000_0000;
   localparam logic [COEF_ROW_W-1:0] RST_COEF_CENTER  = 48'h0000_0100_0000;
   localparam logic [COEF_ROW_W-1:0] RST_COEF_PREV    = 48'h0000_0000_0000;

   typedef struct packed {
      logic [PIX_W-1:0] pixel;
      logic             is_drain;
   } req_word_type;

   typedef struct packed {
      logic [PIX_W-1:0] out_pixel;
      logic             out_last;
   } rsp_word_type;

   // control tag that travels alongside the arithmetic
   typedef struct packed {
      logic valid;
      logic border;
      logic last;
   } tag_type;

   typedef logic [PROD_W-1:0] prod_type;
   typedef logic [SUM_W-1:0]  sum_type;

   function automatic sum_type prod_ext(input prod_type p);
      return {{(SUM_W - PROD_W){p[PROD_W-1]}}, p};
   endfunction

endpackage
`default_nettype wire

// ===== rtl/core/conv3x3_clamped_filter_top.sv =====
`default_nettype none
// channel   direction  handshake              payload
// req_      in         req_valid / req_stall  req_word  (pixel, is_drain)
// rsp_      out        rsp_valid / rsp_stall  rsp_word  (out_pixel, out_last)
// csr_      in         csr_valid / csr_ready  csr_index, csr_data
//
// one word per clock while req_stall is low
// after reset both line buffers are zeroed one column per cycle, all MAX_WIDTH columns;
// req_stall stays high through the sweep, csr writes are taken throughout
// a result held by rsp_stall freezes the whole pipeline, and req_stall rises with it
// frame counters live at the input and update on acceptance; data trails by five stages
module conv3x3_clamped_filter_top (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire c3f_pkg::req_word_type               req_word,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output c3f_pkg::rsp_word_type                    rsp_word,
   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic [c3f_pkg::CSR_IDX_W-1:0]       csr_index,
   input  wire logic [c3f_pkg::COEF_ROW_W-1:0]      csr_data
);

   localparam int COL_W  = c3f_pkg::COL_W;
   localparam int ROW_W  = c3f_pkg::ROW_W;
   localparam int DIM_W  = c3f_pkg::DIM_W;
   localparam int HDIM_W = c3f_pkg::HDIM_W;
   localparam int POS_W  = c3f_pkg::POS_W;
   localparam int PIX_W  = c3f_pkg::PIX_W;
   localparam int TAPS   = c3f_pkg::TAPS;
   localparam int COEF_W = c3f_pkg::COEF_W;
   localparam int SUM_W  = c3f_pkg::SUM_W;
   localparam int FRAC   = c3f_pkg::COEF_FRAC_BITS;

   // clamp configured sizes into 3..MAX
   function automatic logic [DIM_W-1:0] clamp_w(input logic [c3f_pkg::CFG_DIM_W-1:0] v);
      if (32'(v) < 32'(c3f_pkg::MIN_DIM)) begin
         return DIM_W'(c3f_pkg::MIN_DIM);
      end else if (32'(v) > 32'(c3f_pkg::MAX_WIDTH)) begin
         return DIM_W'(c3f_pkg::MAX_WIDTH);
      end else begin
         return DIM_W'(v);
      end
   endfunction

   function automatic logic [HDIM_W-1:0] clamp_h(input logic [c3f_pkg::CFG_DIM_W-1:0] v);
      if (32'(v) < 32'(c3f_pkg::MIN_DIM)) begin
         return HDIM_W'(c3f_pkg::MIN_DIM);
      end else if (32'(v) > 32'(c3f_pkg::MAX_HEIGHT)) begin
         return HDIM_W'(c3f_pkg::MAX_HEIGHT);
      end else begin
         return HDIM_W'(v);
      end
   endfunction

   // ---------------------------------------------------------------- config registers
   logic [c3f_pkg::CFG_DIM_W-1:0]  width_ff;
   logic [c3f_pkg::CFG_DIM_W-1:0]  height_ff;
   logic [c3f_pkg::COEF_ROW_W-1:0] coef_next_ff;
   logic [c3f_pkg::COEF_ROW_W-1:0] coef_center_ff;
   logic [c3f_pkg::COEF_ROW_W-1:0] coef_prev_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff       <= c3f_pkg::RST_IMAGE_WIDTH;
         height_ff      <= c3f_pkg::RST_IMAGE_HEIGHT;
         coef_next_ff   <= c3f_pkg::RST_COEF_NEXT;
         coef_center_ff <= c3f_pkg::RST_COEF_CENTER;
         coef_prev_ff   <= c3f_pkg::RST_COEF_PREV;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            c3f_pkg::CSR_IMAGE_WIDTH: begin
               width_ff <= csr_data[c3f_pkg::CFG_DIM_W-1:0];
            end
            c3f_pkg::CSR_IMAGE_HEIGHT: begin
               height_ff <= csr_data[c3f_pkg::CFG_DIM_W-1:0];
            end
            c3f_pkg::CSR_COEF_NEXT_ROW: begin
               coef_next_ff <= csr_data;
            end
            c3f_pkg::CSR_COEF_CENTER_ROW: begin
               coef_center_ff <= csr_data;
            end
            c3f_pkg::CSR_COEF_PREV_ROW: begin
               coef_prev_ff <= csr_data;
            end
            default: begin
            end
         endcase
      end
   end

   // ---------------------------------------------------------------- clearing sweep
   logic             clr_done_ff;
   logic [COL_W-1:0] clr_addr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_done_ff <= 1'b0;
         clr_addr_ff <= '0;
      end else if (!clr_done_ff) begin
         clr_addr_ff <= clr_addr_ff + 1'b1;
         if (clr_addr_ff == COL_W'(c3f_pkg::MAX_WIDTH - 1)) begin
            clr_done_ff <= 1'b1;
         end
      end
   end

   // ---------------------------------------------------------------- handshake
   logic adv;
   logic req_accept;
   logic rsp_valid_ff;

   // the pipeline moves unless a finished word sits stalled at the output
   assign adv        = !(rsp_valid_ff && rsp_stall);
   assign req_stall  = !adv || !clr_done_ff;
   assign req_accept = req_valid && !req_stall;

   // ---------------------------------------------------------------- frame counters
   logic [DIM_W-1:0]  w_dim;
   logic [HDIM_W-1:0] h_dim;
   logic [COL_W-1:0]  in_col_ff, in_col_in, col_cur;
   logic [COL_W-1:0]  out_col_ff, out_col_in, oc_cur;
   logic [ROW_W-1:0]  out_row_ff, out_row_in;
   logic [POS_W-1:0]  pos_ff, pos_in, pos_inc;
   logic [DIM_W-1:0]  col_inc, oc_inc;
   logic              emit, row_last, col_last, border, frame_end;

   assign w_dim = clamp_w(width_ff);
   assign h_dim = clamp_h(height_ff);

   always_comb begin
      // counters left beyond a smaller width wrap to column zero
      col_cur  = (DIM_W'(in_col_ff) >= w_dim) ? '0 : in_col_ff;
      oc_cur   = (DIM_W'(out_col_ff) >= w_dim) ? '0 : out_col_ff;
      col_inc  = DIM_W'(col_cur) + 1'b1;
      oc_inc   = DIM_W'(oc_cur) + 1'b1;
      pos_inc  = (pos_ff < POS_W'(c3f_pkg::POS_CAP)) ? pos_ff + 1'b1 : pos_ff;
      // output starts once width+1 words have gone by
      emit     = pos_inc >= POS_W'(w_dim) + POS_W'(2);
      row_last = HDIM_W'(out_row_ff) >= h_dim - 1'b1;
      col_last = DIM_W'(oc_cur) >= w_dim - 1'b1;
      border   = (out_row_ff == '0) || row_last || (oc_cur == '0) || col_last;
      frame_end = emit && row_last && col_last;

      in_col_in  = (col_inc >= w_dim) ? '0 : col_inc[COL_W-1:0];
      pos_in     = pos_inc;
      out_col_in = oc_cur;
      out_row_in = out_row_ff;
      if (frame_end) begin
         in_col_in  = '0;
         pos_in     = '0;
         out_col_in = '0;
         out_row_in = '0;
      end else if (emit) begin
         if (oc_inc >= w_dim) begin
            out_col_in = '0;
            out_row_in = out_row_ff + 1'b1;
         end else begin
            out_col_in = oc_inc[COL_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_col_ff  <= '0;
         out_col_ff <= '0;
         out_row_ff <= '0;
         pos_ff     <= '0;
      end else if (req_accept) begin
         in_col_ff  <= in_col_in;
         out_col_ff <= out_col_in;
         out_row_ff <= out_row_in;
         pos_ff     <= pos_in;
      end
   end

   // ---------------------------------------------------------------- stage 1: line buffers
   logic             s1_valid_ff;
   logic [COL_W-1:0] s1_col_ff;
   logic [PIX_W-1:0] s1_px_ff;
   c3f_pkg::tag_type s1_tag_ff;
   logic             s1_byp_ff;
   logic [PIX_W-1:0] s1_byp_a_ff, s1_byp_b_ff;
   logic [PIX_W-1:0] ram_a_rd, ram_b_rd, eff_a, eff_b;
   logic             ram_wr_en;
   logic [COL_W-1:0] ram_wr_addr;
   logic [PIX_W-1:0] ram_a_wr, ram_b_wr;
   logic             s1_write;

   // a word written in the same cycle as the next one reads that column comes by bypass
   assign eff_a    = s1_byp_ff ? s1_byp_a_ff : ram_a_rd;
   assign eff_b    = s1_byp_ff ? s1_byp_b_ff : ram_b_rd;
   assign s1_write = s1_valid_ff && adv;

   always_comb begin
      if (!clr_done_ff) begin
         ram_wr_en   = 1'b1;
         ram_wr_addr = clr_addr_ff;
         ram_a_wr    = '0;
         ram_b_wr    = '0;
      end else begin
         ram_wr_en   = s1_write;
         ram_wr_addr = s1_col_ff;
         ram_a_wr    = eff_b;
         ram_b_wr    = s1_px_ff;
      end
   end

   c3f_ram #(
      .WIDTH (PIX_W),
      .DEPTH (c3f_pkg::MAX_WIDTH)
   ) u_line_a (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_a_wr),
      .rd_en   (req_accept),
      .rd_addr (col_cur),
      .rd_data (ram_a_rd)
   );

   c3f_ram #(
      .WIDTH (PIX_W),
      .DEPTH (c3f_pkg::MAX_WIDTH)
   ) u_line_b (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_b_wr),
      .rd_en   (req_accept),
      .rd_addr (col_cur),
      .rd_data (ram_b_rd)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s1_tag_ff   <= '0;
         s1_byp_ff   <= 1'b0;
      end else if (adv) begin
         s1_valid_ff <= req_accept;
         s1_tag_ff   <= '{valid: req_accept && emit, border: border, last: frame_end};
         s1_byp_ff   <= s1_valid_ff && (s1_col_ff == col_cur);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_col_ff   <= col_cur;
         s1_px_ff    <= req_word.is_drain ? '0 : req_word.pixel;
         s1_byp_a_ff <= eff_b;
         s1_byp_b_ff <= s1_px_ff;
      end
   end

   // ---------------------------------------------------------------- stages 2-3: window cells
   // row 0 is two rows back (coef_prev), row 1 one row back, row 2 the incoming pixel
   logic [PIX_W-1:0]         new_col [TAPS];
   logic [PIX_W-1:0]         win_pix [TAPS][TAPS];
   logic [c3f_pkg::COEF_ROW_W-1:0] coef_row [TAPS];
   c3f_pkg::prod_type        prods [c3f_pkg::WIN_TAPS];

   assign new_col[0]  = eff_a;
   assign new_col[1]  = eff_b;
   assign new_col[2]  = s1_px_ff;
   assign coef_row[0] = coef_prev_ff;
   assign coef_row[1] = coef_center_ff;
   assign coef_row[2] = coef_next_ff;

   for (genvar r = 0; r < TAPS; r++) begin : g_row
      for (genvar c = 0; c < TAPS; c++) begin : g_col
         logic [PIX_W-1:0] feed;
         if (c == TAPS - 1) begin : g_head
            assign feed = new_col[r];
         end else begin : g_body
            assign feed = win_pix[r][c+1];
         end
         c3f_cell u_cell (
            .clock    (clock),
            .reset    (reset),
            .shift_en (s1_write),
            .prod_en  (adv),
            .pix_in   (feed),
            .coef     (coef_row[r][c*COEF_W +: COEF_W]),
            .pix_out  (win_pix[r][c]),
            .prod_out (prods[r*TAPS + c])
         );
      end
   end

   c3f_pkg::tag_type s2_tag_ff, s3_tag_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_tag_ff <= '0;
         s3_tag_ff <= '0;
      end else if (adv) begin
         s2_tag_ff <= s1_tag_ff;
         s3_tag_ff <= s2_tag_ff;
      end
   end

   // ---------------------------------------------------------------- stages 4-5: sum
   c3f_pkg::sum_type sum;
   c3f_pkg::tag_type sum_tag;

   c3f_acc u_acc (
      .clock   (clock),
      .reset   (reset),
      .adv     (adv),
      .prods   (prods),
      .tag_in  (s3_tag_ff),
      .sum_out (sum),
      .tag_out (sum_tag)
   );

   // ---------------------------------------------------------------- output register
   logic [SUM_W-1:0]      mag;
   logic [PIX_W-1:0]      pix_clamped;
   c3f_pkg::rsp_word_type rsp_word_ff;

   // negative sums and border pixels give 0; otherwise drop the fraction and clamp to 255
   always_comb begin
      mag = sum >> FRAC;
      if (sum[SUM_W-1] || sum_tag.border) begin
         pix_clamped = '0;
      end else if (mag > SUM_W'(c3f_pkg::PIX_MAX)) begin
         pix_clamped = PIX_W'(c3f_pkg::PIX_MAX);
      end else begin
         pix_clamped = mag[PIX_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= sum_tag.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_word_ff <= '{out_pixel: pix_clamped, out_last: sum_tag.last};
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   // ---------------------------------------------------------------- assertions
   a_no_accept_while_clearing: assert property (@(posedge clock) disable iff (reset)
      !clr_done_ff |-> !req_accept)
      else $error("word accepted during line buffer sweep");

   a_frame_end_resets: assert property (@(posedge clock) disable iff (reset)
      (req_accept && frame_end) |=>
         (pos_ff == '0) && (out_row_ff == '0) && (out_col_ff == '0) && (in_col_ff == '0))
      else $error("frame counters not cleared after last word");

   a_stall_freezes_pipe: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |=> $stable(s3_tag_ff) && $stable(s1_tag_ff))
      else $error("pipeline moved while output stalled");

endmodule
`default_nettype wire

// ===== rtl/core/c3f_ram.sv =====
`default_nettype none
module c3f_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// ===== rtl/core/c3f_cell.sv =====
`default_nettype none
module c3f_cell (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           shift_en,
   input  wire logic                           prod_en,
   input  wire logic [c3f_pkg::PIX_W-1:0]      pix_in,
   input  wire logic [c3f_pkg::COEF_W-1:0]     coef,
   output logic      [c3f_pkg::PIX_W-1:0]      pix_out,
   output c3f_pkg::prod_type                   prod_out
);

   logic [c3f_pkg::PIX_W-1:0] pix_ff;
   c3f_pkg::prod_type         prod_ff;
   c3f_pkg::prod_type         prod_in;

   // unsigned pixel times signed weight
   assign prod_in = c3f_pkg::PROD_W'($signed({1'b0, pix_ff}) * $signed(coef));

   always_ff @(posedge clock) begin
      if (reset) begin
         pix_ff <= '0;
      end else if (shift_en) begin
         pix_ff <= pix_in;
      end
   end

   always_ff @(posedge clock) begin
      if (prod_en) begin
         prod_ff <= prod_in;
      end
   end

   assign pix_out  = pix_ff;
   assign prod_out = prod_ff;

endmodule
`default_nettype wire

// ===== rtl/core/c3f_acc.sv =====
`default_nettype none
module c3f_acc (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              adv,
   input  wire c3f_pkg::prod_type prods [c3f_pkg::WIN_TAPS],
   input  wire c3f_pkg::tag_type  tag_in,
   output c3f_pkg::sum_type       sum_out,
   output c3f_pkg::tag_type       tag_out
);

   c3f_pkg::sum_type row_sum_ff [c3f_pkg::TAPS];
   c3f_pkg::sum_type row_sum_in [c3f_pkg::TAPS];
   c3f_pkg::sum_type total_ff;
   c3f_pkg::tag_type row_tag_ff;
   c3f_pkg::tag_type total_tag_ff;

   always_comb begin
      for (int r = 0; r < c3f_pkg::TAPS; r++) begin
         row_sum_in[r] = c3f_pkg::prod_ext(prods[r * c3f_pkg::TAPS])
                       + c3f_pkg::prod_ext(prods[r * c3f_pkg::TAPS + 1])
                       + c3f_pkg::prod_ext(prods[r * c3f_pkg::TAPS + 2]);
      end
   end

   // row sums, then the total
   always_ff @(posedge clock) begin
      if (adv) begin
         row_sum_ff <= row_sum_in;
         total_ff   <= row_sum_ff[0] + row_sum_ff[1] + row_sum_ff[2];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_tag_ff   <= '0;
         total_tag_ff <= '0;
      end else if (adv) begin
         row_tag_ff   <= tag_in;
         total_tag_ff <= row_tag_ff;
      end
   end

   assign sum_out = total_ff;
   assign tag_out = total_tag_ff;

endmodule
`default_nettype wire
